// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the SPI register port blocks.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define CRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset
`define CRS_NEVER(lbl, clk, rst_n, cond) \
    `CRS_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== hdl/crspi_pkg.sv =====
// ============================================================================
// CAN SPI register port package
// Shared constants, types and helper functions for the SPI command port.
// ============================================================================
`timescale 1ns / 1ps

package crspi_pkg;

    // Register file geometry
    localparam int REG_COUNT  = 128;
    localparam int ADDR_W     = $clog2(REG_COUNT);
    localparam int ADDR_CNT_W = ADDR_W + 1;
    localparam int DATA_W     = 8;
    localparam int MODE_W     = 3;

    // Command bytes
    localparam logic [DATA_W-1:0] CMD_RESET  = 8'hC0;
    localparam logic [DATA_W-1:0] CMD_READ   = 8'h03;
    localparam logic [DATA_W-1:0] CMD_WRITE  = 8'h02;
    localparam logic [DATA_W-1:0] CMD_MODIFY = 8'h05;

    // Special registers
    localparam logic [ADDR_W-1:0] REG_STAT = ADDR_W'(8'h0E);
    localparam logic [ADDR_W-1:0] REG_CTRL = ADDR_W'(8'h0F);
    localparam logic [DATA_W-1:0] MODE_RST_VAL = 8'h80;
    localparam logic [MODE_W-1:0] MODE_CONF    = MODE_RST_VAL[DATA_W-1 -: MODE_W];

    // Queue depths
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
    localparam int RQ_DEPTH  = 4;
    localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

    // Frame phase of the command decoder
    typedef enum logic [2:0] {
        PH_CMD,
        PH_ADDR,
        PH_READ,
        PH_WRITE,
        PH_MASK,
        PH_MDATA,
        PH_IGNORE
    } t_phase;

    // Operation handed from decoder to executor
    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ,
        OP_WRITE,
        OP_MODIFY,
        OP_RESTORE
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic [DATA_W-1:0]   mask;
    } t_op;

    typedef struct packed {
        logic [DATA_W-1:0] miso;
        logic [MODE_W-1:0] mode;
    } t_res;

    // Address byte reduced into the register range
    function automatic logic [ADDR_W-1:0] addr_mod(input logic [DATA_W-1:0] b);
        logic [DATA_W:0] v;
        v = {1'b0, b};
        for (int i = 0; i < 4; i++) begin
            if (v >= (DATA_W + 1)'(REG_COUNT)) begin
                v = v - (DATA_W + 1)'(REG_COUNT);
            end
        end
        return v[ADDR_W-1:0];
    endfunction

    // Auto-increment with wrap at end of the file
    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_CNT_W-1:0] s;
        s = {1'b0, a} + ADDR_CNT_W'(1);
        if (s >= ADDR_CNT_W'(REG_COUNT)) begin
            s = '0;
        end
        return s[ADDR_W-1:0];
    endfunction

    // Register value after reset
    function automatic logic [DATA_W-1:0] reset_value(input logic [ADDR_W-1:0] a);
        logic [DATA_W-1:0] v;
        v = '0;
        if (a == REG_STAT || a == REG_CTRL) begin
            v = MODE_RST_VAL;
        end
        return v;
    endfunction

endpackage

// ===== hdl/can_controller_spi_register_port_core.sv =====
// ============================================================================
// CAN controller SPI register port
// Device side of the SPI command port: decodes command frames byte by byte and
// runs reset, read, write and bit-modify against the register file.
// ============================================================================
// Usage:
//   Input queue: drive i_spi_byte / i_frame_end and raise push; the item is
//   taken on a clock edge where push is high and full is low. i_frame_end
//   marks the last byte before chip select rises.
//   Result queue: one item per input item, in order. While empty is low,
//   o_miso_byte / o_mode_now show the oldest result; pop takes it.
//   Throughput: one item per cycle while the result queue has room, bounded
//   by the single register RAM port pair used by the executor (one read,
//   one write each cycle).
//   Stalls: when pop is held low the result queue fills, the executor stops
//   pulling operations and the operation queue raises full after four more.
//   Reset: synchronous, active low. Decoder goes to awaiting a command, the
//   register file reads as reset values (mode = configuration) once reset
//   is released; per-entry valid flops are cleared at once, so there is no
//   clearing pass. The reset command does the same for the register file.
// ============================================================================
`timescale 1ns / 1ps

module can_controller_spi_register_port_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [crspi_pkg::DATA_W-1:0]   i_spi_byte,
    input  logic                           i_frame_end,
    output logic                           empty,
    input  logic                           pop,
    output logic [crspi_pkg::DATA_W-1:0]   o_miso_byte,
    output logic [crspi_pkg::MODE_W-1:0]   o_mode_now
);

    logic            op_push;
    logic            op_pop;
    logic            op_empty;
    crspi_pkg::t_op  front_op;
    crspi_pkg::t_op  head_op;

    // Frame decoder
    crspi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_spi_byte  (i_spi_byte),
        .i_frame_end (i_frame_end),
        .o_op_push   (op_push),
        .o_op        (front_op)
    );

    // Decoded operation queue
    crspi_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (front_op),
        .o_full  (full),
        .i_pop   (op_pop),
        .o_op    (head_op),
        .o_empty (op_empty)
    );

    // Register executor and result queue
    crspi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (head_op),
        .i_op_empty  (op_empty),
        .o_op_pop    (op_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_miso_byte (o_miso_byte),
        .o_mode_now  (o_mode_now)
    );

endmodule

// ===== hdl/crspi_ram.sv =====
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data (read-first).
// ============================================================================
`timescale 1ns / 1ps

module crspi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/crspi_front.sv =====
// ============================================================================
// SPI frame decoder
// Tracks the frame phase, command, address pointer and mask; turns each item
// into one register operation.
// ============================================================================
`timescale 1ns / 1ps

module crspi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [crspi_pkg::DATA_W-1:0]   i_spi_byte,
    input  logic                           i_frame_end,
    output logic                           o_op_push,
    output crspi_pkg::t_op                 o_op
);

    crspi_pkg::t_phase                  r_phase, n_phase;
    crspi_pkg::t_op_kind                r_cmd,   n_cmd;
    logic [crspi_pkg::ADDR_W-1:0]       r_addr,  n_addr;
    logic [crspi_pkg::DATA_W-1:0]       r_mask,  n_mask;
    logic                               accept;

    assign accept    = i_push && !i_full;
    assign o_op_push = accept;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            crspi_pkg::PH_CMD: begin
                if (i_spi_byte == crspi_pkg::CMD_READ || i_spi_byte == crspi_pkg::CMD_WRITE ||
                    i_spi_byte == crspi_pkg::CMD_MODIFY) begin
                    n_phase = crspi_pkg::PH_ADDR;
                end else begin
                    n_phase = crspi_pkg::PH_IGNORE;
                end
            end
            crspi_pkg::PH_ADDR: begin
                case (r_cmd)
                    crspi_pkg::OP_READ:  n_phase = crspi_pkg::PH_READ;
                    crspi_pkg::OP_WRITE: n_phase = crspi_pkg::PH_WRITE;
                    default:             n_phase = crspi_pkg::PH_MASK;
                endcase
            end
            crspi_pkg::PH_MASK:  n_phase = crspi_pkg::PH_MDATA;
            crspi_pkg::PH_MDATA: n_phase = crspi_pkg::PH_IGNORE;
            default:             n_phase = r_phase;
        endcase
        if (i_frame_end) begin
            n_phase = crspi_pkg::PH_CMD;
        end
    end

    // Operation and context updates
    always_comb begin
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_mask      = r_mask;
        o_op.kind   = crspi_pkg::OP_NOP;
        o_op.addr   = r_addr;
        o_op.data   = i_spi_byte;
        o_op.mask   = r_mask;
        case (r_phase)
            crspi_pkg::PH_CMD: begin
                case (i_spi_byte)
                    crspi_pkg::CMD_RESET:  o_op.kind = crspi_pkg::OP_RESTORE;
                    crspi_pkg::CMD_READ:   n_cmd = crspi_pkg::OP_READ;
                    crspi_pkg::CMD_WRITE:  n_cmd = crspi_pkg::OP_WRITE;
                    crspi_pkg::CMD_MODIFY: n_cmd = crspi_pkg::OP_MODIFY;
                    default:               n_cmd = crspi_pkg::OP_NOP;
                endcase
            end
            crspi_pkg::PH_ADDR: begin
                n_addr = crspi_pkg::addr_mod(i_spi_byte);
            end
            crspi_pkg::PH_READ: begin
                o_op.kind = crspi_pkg::OP_READ;
                n_addr    = crspi_pkg::addr_inc(r_addr);
            end
            crspi_pkg::PH_WRITE: begin
                o_op.kind = crspi_pkg::OP_WRITE;
                n_addr    = crspi_pkg::addr_inc(r_addr);
            end
            crspi_pkg::PH_MASK: begin
                n_mask = i_spi_byte;
            end
            crspi_pkg::PH_MDATA: begin
                o_op.kind = crspi_pkg::OP_MODIFY;
            end
            default: begin
                o_op.kind = crspi_pkg::OP_NOP;
            end
        endcase
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= crspi_pkg::PH_CMD;
            r_cmd   <= crspi_pkg::OP_NOP;
            r_addr  <= '0;
            r_mask  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_mask  <= n_mask;
        end
    end

endmodule

// ===== hdl/crspi_opq.sv =====
// ============================================================================
// Operation queue
// Short queue of decoded operations between decoder and executor.
// ============================================================================
`timescale 1ns / 1ps

module crspi_opq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crspi_pkg::t_op  i_op,
    output logic            o_full,
    input  logic            i_pop,
    output crspi_pkg::t_op  o_op,
    output logic            o_empty
);

    crspi_pkg::t_op                    r_q [crspi_pkg::OPQ_DEPTH];
    logic [crspi_pkg::OPQ_PTR_W-1:0]   r_wp, r_rp;
    logic [crspi_pkg::OPQ_CNT_W-1:0]   r_cnt;
    logic                              do_push, do_pop;

    assign o_full  = (r_cnt == crspi_pkg::OPQ_CNT_W'(crspi_pkg::OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == crspi_pkg::OPQ_PTR_W'(crspi_pkg::OPQ_DEPTH - 1)) ?
                        '0 : r_wp + crspi_pkg::OPQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == crspi_pkg::OPQ_PTR_W'(crspi_pkg::OPQ_DEPTH - 1)) ?
                        '0 : r_rp + crspi_pkg::OPQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + crspi_pkg::OPQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - crspi_pkg::OPQ_CNT_W'(1);
            end
        end
    end

endmodule

// ===== hdl/crspi_back.sv =====
// ============================================================================
// Register executor
// Carries out register operations against the register RAM and queues one
// result item per operation.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crspi_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  crspi_pkg::t_op                 i_op,
    input  logic                           i_op_empty,
    output logic                           o_op_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [crspi_pkg::DATA_W-1:0]   o_miso_byte,
    output logic [crspi_pkg::MODE_W-1:0]   o_mode_now
);

    // Execute stage
    logic                               r_s1_valid;
    crspi_pkg::t_op                     r_s1_op;
    logic                               r_byp_hit,  n_byp_hit;
    logic [crspi_pkg::DATA_W-1:0]       r_byp_data;
    logic [crspi_pkg::MODE_W-1:0]       r_mode,     n_mode;
    logic [crspi_pkg::REG_COUNT-1:0]    r_vld;

    logic [crspi_pkg::DATA_W-1:0]       ram_rdata;
    logic [crspi_pkg::DATA_W-1:0]       old_val;
    logic [crspi_pkg::DATA_W-1:0]       wdata;
    logic                               ram_we;
    logic                               s1_stat;
    logic                               restore;
    crspi_pkg::t_res                    res;

    // Result queue
    crspi_pkg::t_res                    r_rq [crspi_pkg::RQ_DEPTH];
    logic [crspi_pkg::RQ_PTR_W-1:0]     r_rq_wp, r_rq_rp;
    logic [crspi_pkg::RQ_CNT_W-1:0]     r_rq_cnt;
    logic                               rq_pop;

    // Issue only with room for this item and the one in flight
    assign o_op_pop = !i_op_empty &&
                      ((r_rq_cnt + crspi_pkg::RQ_CNT_W'(r_s1_valid)) <
                       crspi_pkg::RQ_CNT_W'(crspi_pkg::RQ_DEPTH));

    crspi_ram #(
        .WIDTH (crspi_pkg::DATA_W),
        .DEPTH (crspi_pkg::REG_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_op.addr),
        .i_wdata (wdata),
        .i_raddr (i_op.addr),
        .o_rdata (ram_rdata)
    );

    // Current register value: status from flops, unwritten entries at reset value,
    // same-address write from the previous cycle bypassed
    always_comb begin
        s1_stat = (r_s1_op.addr == crspi_pkg::REG_STAT);
        if (s1_stat) begin
            old_val = {r_mode, {(crspi_pkg::DATA_W - crspi_pkg::MODE_W){1'b0}}};
        end else if (!r_vld[r_s1_op.addr]) begin
            old_val = crspi_pkg::reset_value(r_s1_op.addr);
        end else if (r_byp_hit) begin
            old_val = r_byp_data;
        end else begin
            old_val = ram_rdata;
        end
    end

    // Write data, mode update and result
    always_comb begin
        wdata    = r_s1_op.data;
        ram_we   = 1'b0;
        restore  = 1'b0;
        res.miso = '0;
        case (r_s1_op.kind)
            crspi_pkg::OP_READ: begin
                res.miso = old_val;
            end
            crspi_pkg::OP_WRITE: begin
                ram_we = r_s1_valid && !s1_stat;
            end
            crspi_pkg::OP_MODIFY: begin
                wdata  = (old_val & ~r_s1_op.mask) | (r_s1_op.data & r_s1_op.mask);
                ram_we = r_s1_valid && !s1_stat;
            end
            crspi_pkg::OP_RESTORE: begin
                restore = r_s1_valid;
            end
            default: begin
                res.miso = '0;
            end
        endcase
        n_mode = r_mode;
        if (restore) begin
            n_mode = crspi_pkg::MODE_CONF;
        end else if (ram_we && r_s1_op.addr == crspi_pkg::REG_CTRL) begin
            n_mode = wdata[crspi_pkg::DATA_W-1 -: crspi_pkg::MODE_W];
        end
        res.mode  = n_mode;
        n_byp_hit = ram_we && (r_s1_op.addr == i_op.addr);
    end

    // Stage and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp_hit  <= 1'b0;
            r_mode     <= crspi_pkg::MODE_CONF;
            r_vld      <= '0;
        end else begin
            r_s1_valid <= o_op_pop;
            r_byp_hit  <= n_byp_hit;
            r_mode     <= n_mode;
            if (restore) begin
                r_vld <= '0;
            end else if (ram_we) begin
                r_vld[r_s1_op.addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_s1_op <= i_op;
        end
        r_byp_data <= wdata;
    end

    // Result queue
    assign o_empty     = (r_rq_cnt == '0);
    assign rq_pop      = i_pop && !o_empty;
    assign o_miso_byte = r_rq[r_rq_rp].miso;
    assign o_mode_now  = r_rq[r_rq_rp].mode;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_rq[r_rq_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= '0;
            r_rq_rp  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_rq_wp <= (r_rq_wp == crspi_pkg::RQ_PTR_W'(crspi_pkg::RQ_DEPTH - 1)) ?
                           '0 : r_rq_wp + crspi_pkg::RQ_PTR_W'(1);
            end
            if (rq_pop) begin
                r_rq_rp <= (r_rq_rp == crspi_pkg::RQ_PTR_W'(crspi_pkg::RQ_DEPTH - 1)) ?
                           '0 : r_rq_rp + crspi_pkg::RQ_PTR_W'(1);
            end
            if (r_s1_valid && !rq_pop) begin
                r_rq_cnt <= r_rq_cnt + crspi_pkg::RQ_CNT_W'(1);
            end else if (rq_pop && !r_s1_valid) begin
                r_rq_cnt <= r_rq_cnt - crspi_pkg::RQ_CNT_W'(1);
            end
        end
    end

    // Checks
    `CRS_ASSERT(a_rq_no_overflow, i_clk, i_rst_n, (r_s1_valid && (r_rq_cnt == crspi_pkg::RQ_CNT_W'(crspi_pkg::RQ_DEPTH))) |-> rq_pop)
    `CRS_ASSERT(a_restore_conf_mode, i_clk, i_rst_n, (r_s1_valid && r_s1_op.kind == crspi_pkg::OP_RESTORE) |=> (r_mode == crspi_pkg::MODE_CONF && r_vld == '0))
    `CRS_NEVER(a_no_status_write, i_clk, i_rst_n, ram_we && (r_s1_op.addr == crspi_pkg::REG_STAT))

endmodule
